/* rtl/gsg_pkg.sv */
// shared types, constants, microprogram and saturating helpers for the geodesic step
package gsg_pkg;

  localparam int FRAC_BITS_DEF = 40;
  localparam int QDEPTH = 4;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {63{1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {63{1'b0}}};

  // configuration register indexes
  localparam logic CFG_MASS = 1'b0;
  localparam logic CFG_STEP = 1'b1;

  // datapath operations of the back sequencer
  typedef enum logic [2:0] {
    OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_NEG, OP_CHK, OP_END
  } op_t;

  // register file slots; indexes from K_BASE up select constants
  localparam logic [4:0] R_T    = 5'd0;
  localparam logic [4:0] R_R    = 5'd1;
  localparam logic [4:0] R_P    = 5'd2;
  localparam logic [4:0] R_UT   = 5'd3;
  localparam logic [4:0] R_UR   = 5'd4;
  localparam logic [4:0] R_UP   = 5'd5;
  localparam logic [4:0] R_F    = 5'd6;
  localparam logic [4:0] R_A    = 5'd7;
  localparam logic [4:0] R_G    = 5'd8;
  localparam logic [4:0] R_H    = 5'd9;
  localparam logic [4:0] R_INV  = 5'd10;
  localparam logic [4:0] X1     = 5'd11;
  localparam logic [4:0] X2     = 5'd12;
  localparam logic [4:0] X3     = 5'd13;
  localparam logic [4:0] X4     = 5'd14;
  localparam logic [4:0] K_BASE = 5'd24;
  localparam logic [4:0] K_MASS = 5'd24;
  localparam logic [4:0] K_TM   = 5'd25;
  localparam logic [4:0] K_STEP = 5'd26;
  localparam logic [4:0] K_ONE  = 5'd27;
  localparam logic [4:0] K_TWO  = 5'd28;

  typedef struct packed {
    op_t        op;
    logic [4:0] d;
    logic [4:0] a;
    logic [4:0] b;
  } ins_t;

  // entry point of the horizon test
  localparam logic [5:0] PC_CHK = 6'd36;

  typedef struct packed {
    logic horizon_hit;
    fx_t  up;
    fx_t  ur;
    fx_t  ut;
    fx_t  p;
    fx_t  r;
    fx_t  t;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic horizon_hit;
    fx_t  inv;
    fx_t  up;
    fx_t  ur;
    fx_t  ut;
    fx_t  p;
    fx_t  r;
    fx_t  t;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_LOAD, BK_FETCH, BK_EXEC, BK_WAIT, BK_DRAIN, BK_PUSH
  } bk_state_t;

  // microprogram: acceleration, symplectic update, horizon test, invariant
  function automatic ins_t prog(input logic [5:0] pc);
    ins_t i;
    case (pc)
      6'd0:  i = '{OP_DIV, X1, K_TM, R_R};
      6'd1:  i = '{OP_SUB, R_F, K_ONE, X1};
      6'd2:  i = '{OP_MUL, X1, R_R, R_R};
      6'd3:  i = '{OP_DIV, R_A, K_MASS, X1};
      6'd4:  i = '{OP_DIV, R_G, R_A, R_F};
      6'd5:  i = '{OP_MUL, R_H, R_A, R_F};
      6'd6:  i = '{OP_ADD, X1, R_G, R_G};
      6'd7:  i = '{OP_NEG, X1, X1, X1};
      6'd8:  i = '{OP_MUL, X1, X1, R_UT};
      6'd9:  i = '{OP_MUL, X2, X1, R_UR};
      6'd10: i = '{OP_NEG, X1, R_H, R_H};
      6'd11: i = '{OP_MUL, X3, R_UT, R_UT};
      6'd12: i = '{OP_MUL, X1, X1, X3};
      6'd13: i = '{OP_MUL, X3, R_UR, R_UR};
      6'd14: i = '{OP_MUL, X3, R_G, X3};
      6'd15: i = '{OP_ADD, X1, X1, X3};
      6'd16: i = '{OP_MUL, X3, R_R, R_F};
      6'd17: i = '{OP_MUL, X4, R_UP, R_UP};
      6'd18: i = '{OP_MUL, X3, X3, X4};
      6'd19: i = '{OP_ADD, X3, X1, X3};
      6'd20: i = '{OP_DIV, X1, K_TWO, R_R};
      6'd21: i = '{OP_NEG, X1, X1, X1};
      6'd22: i = '{OP_MUL, X1, X1, R_UR};
      6'd23: i = '{OP_MUL, X1, X1, R_UP};
      6'd24: i = '{OP_MUL, X2, X2, K_STEP};
      6'd25: i = '{OP_ADD, R_UT, R_UT, X2};
      6'd26: i = '{OP_MUL, X3, X3, K_STEP};
      6'd27: i = '{OP_ADD, R_UR, R_UR, X3};
      6'd28: i = '{OP_MUL, X1, X1, K_STEP};
      6'd29: i = '{OP_ADD, R_UP, R_UP, X1};
      6'd30: i = '{OP_MUL, X1, R_UT, K_STEP};
      6'd31: i = '{OP_ADD, R_T, R_T, X1};
      6'd32: i = '{OP_MUL, X1, R_UR, K_STEP};
      6'd33: i = '{OP_ADD, R_R, R_R, X1};
      6'd34: i = '{OP_MUL, X1, R_UP, K_STEP};
      6'd35: i = '{OP_ADD, R_P, R_P, X1};
      6'd36: i = '{OP_CHK, X1, R_R, K_TM};
      6'd37: i = '{OP_DIV, X1, K_TM, R_R};
      6'd38: i = '{OP_SUB, R_F, K_ONE, X1};
      6'd39: i = '{OP_NEG, X1, R_F, R_F};
      6'd40: i = '{OP_MUL, X2, R_UT, R_UT};
      6'd41: i = '{OP_MUL, X1, X1, X2};
      6'd42: i = '{OP_DIV, X2, K_ONE, R_F};
      6'd43: i = '{OP_MUL, X3, R_UR, R_UR};
      6'd44: i = '{OP_MUL, X2, X2, X3};
      6'd45: i = '{OP_ADD, X1, X1, X2};
      6'd46: i = '{OP_MUL, X2, R_R, R_R};
      6'd47: i = '{OP_MUL, X3, R_UP, R_UP};
      6'd48: i = '{OP_MUL, X2, X2, X3};
      6'd49: i = '{OP_ADD, R_INV, X1, X2};
      default: i = '{OP_END, X1, X1, X1};
    endcase
    return i;
  endfunction

  function automatic logic [63:0] mag(input fx_t x);
    return x[63] ? (64'd0 - 64'(x)) : 64'(x);
  endfunction

  function automatic fx_t from_mag(input logic neg, input logic [63:0] m);
    fx_t y;
    if (neg) begin
      y = m[63] ? FX_MIN : fx_t'(64'd0 - m);
    end else begin
      y = m[63] ? FX_MAX : fx_t'(m);
    end
    return y;
  endfunction

  function automatic fx_t sat65(input logic signed [64:0] s);
    fx_t y;
    if (s[64] != s[63]) begin
      y = s[64] ? FX_MIN : FX_MAX;
    end else begin
      y = s[63:0];
    end
    return y;
  endfunction

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    return sat65(65'({a[63], a}) + 65'({b[63], b}));
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    return sat65(65'({a[63], a}) - 65'({b[63], b}));
  endfunction

  function automatic fx_t sat_neg(input fx_t a);
    return (a == FX_MIN) ? FX_MAX : -a;
  endfunction

endpackage

/* rtl/gsg_front.sv */
// front end: accepts input beats, forms 2M and flags states at or inside the horizon
module gsg_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [383:0]          in_tdata,
  input  logic [62:0]           mass,
  input  logic                  q_full,
  output logic                  q_push,
  output gsg_pkg::entry_t       q_entry,
  output gsg_pkg::fx_t          two_mass
);

  // 2M, saturating to the largest positive value
  assign two_mass = mass[62] ? gsg_pkg::FX_MAX : gsg_pkg::fx_t'({1'b0, mass[61:0], 1'b0});

  // unpack the beat and classify
  always_comb begin
    q_entry.t           = in_tdata[63:0];
    q_entry.r           = in_tdata[127:64];
    q_entry.p           = in_tdata[191:128];
    q_entry.ut          = in_tdata[255:192];
    q_entry.ur          = in_tdata[319:256];
    q_entry.up          = in_tdata[383:320];
    q_entry.horizon_hit = (q_entry.r <= two_mass);
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

/* rtl/gsg_queue.sv */
// short queue of classified states between front and back
module gsg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gsg_pkg::entry_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output gsg_pkg::entry_t head
);

  localparam int QAW = $clog2(gsg_pkg::QDEPTH);

  gsg_pkg::entry_t slot_r [gsg_pkg::QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QAW:0]    count_r;

  assign full      = (count_r == (QAW+1)'(gsg_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/gsg_mul.sv */
// fixed point multiplier: four 32x32 partial products over successive cycles
module gsg_mul #(
  parameter int FRAC_BITS = gsg_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  gsg_pkg::fx_t a,
  input  gsg_pkg::fx_t b,
  output logic         done,
  output gsg_pkg::fx_t y
);

  logic         busy_r, done_r, neg_r;
  logic [2:0]   cnt_r;
  logic [63:0]  x_r, z_r, pp_r;
  logic [1:0]   ppk_r;
  logic [127:0] acc_r, pp_sh;
  logic [31:0]  xs, zs;
  logic         over;
  logic [63:0]  m;
  gsg_pkg::fx_t y_r;

  // operand halves for the current partial product
  assign xs = cnt_r[1] ? x_r[63:32] : x_r[31:0];
  assign zs = cnt_r[0] ? z_r[63:32] : z_r[31:0];

  // align the registered partial product
  always_comb begin
    case (ppk_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'd0};
      default: pp_sh = {32'd0, pp_r, 32'd0};
    endcase
  end

  // truncate to the fraction width and saturate
  assign over = |(acc_r >> (64 + FRAC_BITS));
  assign m    = 64'(acc_r >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        neg_r  <= a[63] ^ b[63];
        x_r    <= gsg_pkg::mag(a);
        z_r    <= gsg_pkg::mag(b);
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r < 3'd4) begin
          pp_r  <= xs * zs;
          ppk_r <= cnt_r[1:0];
        end
        if (cnt_r >= 3'd1 && cnt_r <= 3'd4) acc_r <= acc_r + pp_sh;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          y_r    <= over ? (neg_r ? gsg_pkg::FX_MIN : gsg_pkg::FX_MAX)
                         : gsg_pkg::from_mag(neg_r, m);
        end
      end
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

/* rtl/gsg_div.sv */
// fixed point divider: restoring, one quotient bit per cycle
module gsg_div #(
  parameter int FRAC_BITS = gsg_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  gsg_pkg::fx_t a,
  input  gsg_pkg::fx_t b,
  output logic         done,
  output gsg_pkg::fx_t y
);

  logic         chk_r, iter_r, done_r, neg_r, aneg_r;
  logic [5:0]   cnt_r;
  logic [63:0]  x_r, d_r, lo_r, q_r, hi, q_nxt;
  logic [64:0]  rem_r, rem_sh;
  logic         ge;
  gsg_pkg::fx_t y_r;

  assign hi     = x_r >> (64 - FRAC_BITS);
  assign rem_sh = {rem_r[63:0], lo_r[63]};
  assign ge     = (rem_sh >= {1'b0, d_r});
  assign q_nxt  = {q_r[62:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r  <= 1'b0;
      iter_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        chk_r  <= 1'b1;
        neg_r  <= a[63] ^ b[63];
        aneg_r <= a[63];
        x_r    <= gsg_pkg::mag(a);
        d_r    <= gsg_pkg::mag(b);
      end else if (chk_r) begin
        // zero numerator, zero divisor and quotient overflow settle at once
        chk_r <= 1'b0;
        if (x_r == '0) begin
          done_r <= 1'b1;
          y_r    <= '0;
        end else if (d_r == '0) begin
          done_r <= 1'b1;
          y_r    <= aneg_r ? gsg_pkg::FX_MIN : gsg_pkg::FX_MAX;
        end else if (hi >= d_r) begin
          done_r <= 1'b1;
          y_r    <= neg_r ? gsg_pkg::FX_MIN : gsg_pkg::FX_MAX;
        end else begin
          iter_r <= 1'b1;
          rem_r  <= {1'b0, hi};
          lo_r   <= x_r << FRAC_BITS;
          q_r    <= '0;
          cnt_r  <= '0;
        end
      end else if (iter_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
        lo_r  <= {lo_r[62:0], 1'b0};
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          iter_r <= 1'b0;
          done_r <= 1'b1;
          y_r    <= gsg_pkg::from_mag(neg_r, q_nxt);
        end
      end
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

/* rtl/gsg_back.sv */
// back end: microprogrammed sequencer over a register file, shared multiplier and divider
module gsg_back #(
  parameter int FRAC_BITS = gsg_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  gsg_pkg::entry_t q_head,
  output logic            q_pop,
  input  logic [62:0]     mass,
  input  logic [62:0]     step_size,
  input  gsg_pkg::fx_t    two_mass,
  output logic            mul_start,
  input  logic            mul_done,
  input  gsg_pkg::fx_t    mul_y,
  output logic            div_start,
  input  logic            div_done,
  input  gsg_pkg::fx_t    div_y,
  output gsg_pkg::fx_t    opa,
  output gsg_pkg::fx_t    opb,
  output logic            out_valid,
  input  logic            out_ready,
  output gsg_pkg::result_t out_res
);

  localparam gsg_pkg::fx_t K1 = gsg_pkg::fx_t'(64'd1 << FRAC_BITS);
  localparam gsg_pkg::fx_t K2 = gsg_pkg::fx_t'(64'd1 << (FRAC_BITS + 1));

  gsg_pkg::bk_state_t state_r, state_nxt;
  logic [5:0]  pc_r, pc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        inside_r, inside_nxt, valid_r, valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  gsg_pkg::result_t res_r, res_nxt, out_r, out_nxt;
  gsg_pkg::ins_t ins;

  logic [63:0] mem [32];
  logic        we;
  logic [4:0]  wa, ra0, ra1, ia_r, ib_r;
  logic [63:0] wd, rd0_r, rd1_r;

  function automatic gsg_pkg::fx_t kval(input logic [4:0] idx, input logic [62:0] ms,
                                         input logic [62:0] st, input gsg_pkg::fx_t tm);
    gsg_pkg::fx_t v;
    case (idx)
      gsg_pkg::K_MASS: v = {1'b0, ms};
      gsg_pkg::K_TM:   v = tm;
      gsg_pkg::K_STEP: v = {1'b0, st};
      gsg_pkg::K_ONE:  v = K1;
      default:         v = K2;
    endcase
    return v;
  endfunction

  // register file with registered read ports
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
    ia_r  <= ra0;
    ib_r  <= ra1;
  end

  // operands: register file or constants
  assign opa = (ia_r >= gsg_pkg::K_BASE) ? kval(ia_r, mass, step_size, two_mass) : rd0_r;
  assign opb = (ib_r >= gsg_pkg::K_BASE) ? kval(ib_r, mass, step_size, two_mass) : rd1_r;
  assign ins = gsg_pkg::prog(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gsg_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pc_r     <= pc_nxt;
    cnt_r    <= cnt_nxt;
    inside_r <= inside_nxt;
    valid_r  <= valid_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    inside_nxt    = inside_r;
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    wa            = ins.d;
    wd            = '0;
    ra0           = ins.a;
    ra1           = ins.b;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    q_pop         = 1'b0;
    case (state_r)
      gsg_pkg::BK_IDLE: begin
        cnt_nxt = '0;
        if (q_not_empty) state_nxt = gsg_pkg::BK_LOAD;
      end
      gsg_pkg::BK_LOAD: begin
        // copy the six state words into the register file
        we = 1'b1;
        wa = 5'(cnt_r);
        case (cnt_r)
          3'd0:    wd = q_head.t;
          3'd1:    wd = q_head.r;
          3'd2:    wd = q_head.p;
          3'd3:    wd = q_head.ut;
          3'd4:    wd = q_head.ur;
          default: wd = q_head.up;
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          q_pop      = 1'b1;
          inside_nxt = q_head.horizon_hit;
          pc_nxt     = q_head.horizon_hit ? gsg_pkg::PC_CHK : 6'd0;
          state_nxt  = gsg_pkg::BK_FETCH;
        end
      end
      gsg_pkg::BK_FETCH: begin
        state_nxt = gsg_pkg::BK_EXEC;
      end
      gsg_pkg::BK_EXEC: begin
        cnt_nxt = '0;
        case (ins.op)
          gsg_pkg::OP_MUL: begin
            mul_start = 1'b1;
            state_nxt = gsg_pkg::BK_WAIT;
          end
          gsg_pkg::OP_DIV: begin
            div_start = 1'b1;
            state_nxt = gsg_pkg::BK_WAIT;
          end
          gsg_pkg::OP_ADD, gsg_pkg::OP_SUB, gsg_pkg::OP_NEG: begin
            we = 1'b1;
            if (ins.op == gsg_pkg::OP_ADD)      wd = gsg_pkg::sat_add(opa, opb);
            else if (ins.op == gsg_pkg::OP_SUB) wd = gsg_pkg::sat_sub(opa, opb);
            else                                wd = gsg_pkg::sat_neg(opa);
            pc_nxt    = pc_r + 6'd1;
            state_nxt = gsg_pkg::BK_FETCH;
          end
          gsg_pkg::OP_CHK: begin
            // result radius beyond the horizon: go on to the invariant
            if (opa > opb) begin
              pc_nxt    = pc_r + 6'd1;
              state_nxt = gsg_pkg::BK_FETCH;
            end else begin
              valid_nxt = 1'b0;
              state_nxt = gsg_pkg::BK_DRAIN;
            end
          end
          default: begin
            valid_nxt = 1'b1;
            state_nxt = gsg_pkg::BK_DRAIN;
          end
        endcase
      end
      gsg_pkg::BK_WAIT: begin
        if ((ins.op == gsg_pkg::OP_MUL) ? mul_done : div_done) begin
          we        = 1'b1;
          wd        = (ins.op == gsg_pkg::OP_MUL) ? mul_y : div_y;
          pc_nxt    = pc_r + 6'd1;
          state_nxt = gsg_pkg::BK_FETCH;
        end
      end
      gsg_pkg::BK_DRAIN: begin
        // read the result words two at a time, capture them in the following cycle
        case (cnt_r[1:0])
          2'd0:    begin ra0 = gsg_pkg::R_T;   ra1 = gsg_pkg::R_R;   end
          2'd1:    begin ra0 = gsg_pkg::R_P;   ra1 = gsg_pkg::R_UT;  end
          2'd2:    begin ra0 = gsg_pkg::R_UR;  ra1 = gsg_pkg::R_UP;  end
          default: begin ra0 = gsg_pkg::R_INV; ra1 = gsg_pkg::R_INV; end
        endcase
        res_nxt.horizon_hit = inside_r;
        res_nxt.valid       = valid_r;
        case (cnt_r)
          3'd1: begin res_nxt.t  = rd0_r; res_nxt.r  = rd1_r; end
          3'd2: begin res_nxt.p  = rd0_r; res_nxt.ut = rd1_r; end
          3'd3: begin res_nxt.ur = rd0_r; res_nxt.up = rd1_r; end
          3'd4: res_nxt.inv = valid_r ? rd0_r : '0;
          default: ;
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) state_nxt = gsg_pkg::BK_PUSH;
      end
      gsg_pkg::BK_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = gsg_pkg::BK_IDLE;
        end
      end
      default: state_nxt = gsg_pkg::BK_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

/* rtl/schwarzschild_geodesic_step.sv */
// Schwarzschild equatorial geodesic step, top level. For a state outside the horizon, six
// divisions through the serial divider (one quotient bit a cycle) dominate the time from
// queue to output register, with 26 multiplications on the shared 32x32 multiplier and
// the adds and compares besides. The input side accepts one beat a cycle until the
// four-entry queue is full; the output register lets the next state start while a result
// waits to be taken.
module schwarzschild_geodesic_step #(
  parameter int FRAC_BITS = gsg_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // t, r, phi, dt/dtau, dr/dtau, dphi/dtau, 64 bits each from bit 0
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_time, out_radius, out_angle, out_vel_time, out_vel_radius, out_vel_angle, invariant
  output logic [447:0] out_tdata,
  // inside_horizon, invariant_valid
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [62:0]  cfg_wdata
);

  localparam logic [62:0] MASS_RST = 63'(64'd1 << FRAC_BITS);
  localparam logic [62:0] STEP_RST = 63'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  logic [62:0] mass_r, step_r;
  logic        q_full, q_push, q_pop, q_not_empty;
  gsg_pkg::entry_t q_entry, q_head;
  gsg_pkg::fx_t two_mass, opa, opb, mul_y, div_y;
  logic        mul_start, mul_done, div_start, div_done;
  gsg_pkg::result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= MASS_RST;
      step_r <= STEP_RST;
    end else if (cfg_we) begin
      if (cfg_index == gsg_pkg::CFG_MASS) mass_r <= cfg_wdata;
      if (cfg_index == gsg_pkg::CFG_STEP) step_r <= cfg_wdata;
    end
  end

  gsg_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .mass      (mass_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .two_mass  (two_mass)
  );

  gsg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  gsg_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk), .rst_n (rst_n), .start (mul_start), .a (opa), .b (opb),
    .done (mul_done), .y (mul_y)
  );

  gsg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk), .rst_n (rst_n), .start (div_start), .a (opa), .b (opb),
    .done (div_done), .y (div_y)
  );

  gsg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .mass        (mass_r),
    .step_size   (step_r),
    .two_mass    (two_mass),
    .mul_start   (mul_start),
    .mul_done    (mul_done),
    .mul_y       (mul_y),
    .div_start   (div_start),
    .div_done    (div_done),
    .div_y       (div_y),
    .opa         (opa),
    .opb         (opb),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  // result beat packing
  assign out_tdata = {res.inv, res.up, res.ur, res.ut, res.p, res.r, res.t};
  assign out_tuser = {res.valid, res.horizon_hit};

endmodule

/* rtl/gsg_checker.sv */
// port level checks on the result channel, bound to the top level
module gsg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [447:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a state passed through at the horizon never carries a valid invariant
  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("invariant valid on a state inside the horizon");

  // an invalid invariant reads as zero
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[447:384] == 64'd0)
    else $error("invalid invariant not zero");

  // no result beat straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind schwarzschild_geodesic_step gsg_checker u_gsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
